[src/assert_macros.svh]
// Concurrent checks used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[src/mda_pkg.sv]
package mda_pkg;

	localparam int REQ_W   = 24;
	localparam int MOM_W   = 23;
	localparam int RES_W   = 16;
	localparam int VOLT_W  = 16;
	localparam int DUTY_W  = 16;
	localparam int ALLOC_W = 24;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_MOM_X  = 3'd0;
	localparam reg_idx_t REG_MOM_Y  = 3'd1;
	localparam reg_idx_t REG_MOM_Z  = 3'd2;
	localparam reg_idx_t REG_RES_X  = 3'd3;
	localparam reg_idx_t REG_RES_Y  = 3'd4;
	localparam reg_idx_t REG_RES_Z  = 3'd5;
	localparam reg_idx_t REG_VWORST = 3'd6;
	localparam reg_idx_t REG_BUDGET = 3'd7;

	localparam logic [MOM_W-1:0]  MOM_RST    = 23'd100000;
	localparam logic [RES_W-1:0]  RES_RST    = 16'd30000;
	localparam logic [VOLT_W-1:0] VWORST_RST = 16'd8400;
	localparam logic [15:0]       BUDGET_RST = 16'd1000;

	localparam int DUTY_POS_LIM = 32767;
	localparam int DUTY_NEG_LIM = 32768;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 16'h7fff;
	localparam logic [DUTY_W-1:0] DUTY_MIN = 16'h8000;

endpackage

[src/mda_div.sv]
module mda_div #(
	parameter int DW = 16,
	parameter int QW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [DW-1:0] rem_i,
	input  logic [QW-1:0] low_i,
	input  logic [DW-1:0] den_i,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output logic [QW-1:0] quo_o,
	output logic [SW-1:0] side_o
);

	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] low_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [SW-1:0] side_s [QW];
	logic [QW-1:0] vld_s;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_c;
		logic [QW-1:0] low_c;
		logic [DW-1:0] den_c;
		logic [SW-1:0] side_c;
		logic          vld_c;
		logic [DW:0]   t;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_c  = rem_i;
			assign low_c  = low_i;
			assign den_c  = den_i;
			assign side_c = side_i;
			assign vld_c  = vld_i;
		end else begin : g_next
			assign rem_c  = rem_s[k-1];
			assign low_c  = low_s[k-1];
			assign den_c  = den_s[k-1];
			assign side_c = side_s[k-1];
			assign vld_c  = vld_s[k-1];
		end

		assign t  = {rem_c, low_c[QW-1]};
		assign ge = t >= {1'b0, den_c};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DW'(t - {1'b0, den_c}) : t[DW-1:0];
				low_s[k]  <= {low_c[QW-2:0], ge};
				den_s[k]  <= den_c;
				side_s[k] <= side_c;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_c;
			end
		end
	end

	assign vld_o  = vld_s[QW-1];
	assign quo_o  = low_s[QW-1];
	assign side_o = side_s[QW-1];

endmodule

[src/magnetorquer_dipole_allocator.sv]
// Magnetorquer dipole allocator.
// Input channel (in_valid / in_stall): one word holds a requested dipole
// req_x/y/z, the monitor_alive flag and bus_voltage_mv. Output channel
// (out_valid / out_stall): one word holds the duty cycles duty_x/y/z in
// signed Q.F and the allocated dipoles alloc_x/y/z. Every input word gives
// exactly one output word, in order.
// The APB port sets full-scale moments, coil resistances, the fallback
// voltage and the power budget; write it only while the pipeline is empty.
// The datapath is a chain of bit-per-stage dividers (normalize, clamp,
// power, budget) and a bit-per-stage square root. One word enters per
// cycle, back to back, while the output is not stalled.
// When the receiver stalls a valid output, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the default register values.
`include "assert_macros.svh"

module magnetorquer_dipole_allocator
	import mda_pkg::*;
#(
	parameter int DUTY_FRAC_BITS = 15
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [REQ_W-1:0]   req_x,
	input  logic signed [REQ_W-1:0]   req_y,
	input  logic signed [REQ_W-1:0]   req_z,
	input  logic                      monitor_alive,
	input  logic [VOLT_W-1:0]         bus_voltage_mv,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DUTY_W-1:0]  duty_x,
	output logic signed [DUTY_W-1:0]  duty_y,
	output logic signed [DUTY_W-1:0]  duty_z,
	output logic signed [ALLOC_W-1:0] alloc_x,
	output logic signed [ALLOC_W-1:0] alloc_y,
	output logic signed [ALLOC_W-1:0] alloc_z
);

	localparam int F    = DUTY_FRAC_BITS;
	localparam int N1W  = REQ_W + F + 1;
	localparam int MW   = REQ_W + F;
	localparam int AW   = F + 1;
	localparam int CQW  = F + 2;
	localparam int PPW  = AW + 2 * VOLT_W;
	localparam int PW   = F + 2 * VOLT_W;
	localparam int SUMW = PW + 2;
	localparam int RQW  = 2 * F;
	localparam int SW4  = 3 * AW + 4;
	localparam int PRW  = AW + MOM_W;
	localparam int TW   = PRW - F + 1;
	localparam int CW   = (AW > 17) ? AW : 17;
	localparam logic [MW-1:0] ONE_M = MW'(1) << F;
	localparam logic [AW-1:0] ONE_A = AW'(1) << F;

	// configuration registers
	logic [MOM_W-1:0]  max_moment_x_q, max_moment_y_q, max_moment_z_q;
	logic [RES_W-1:0]  coil_res_x_q, coil_res_y_q, coil_res_z_q;
	logic [VOLT_W-1:0] worst_voltage_q;
	logic [15:0]       power_budget_q;
	reg_idx_t          widx;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_moment_x_q  <= MOM_RST;
			max_moment_y_q  <= MOM_RST;
			max_moment_z_q  <= MOM_RST;
			coil_res_x_q    <= RES_RST;
			coil_res_y_q    <= RES_RST;
			coil_res_z_q    <= RES_RST;
			worst_voltage_q <= VWORST_RST;
			power_budget_q  <= BUDGET_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (widx)
				REG_MOM_X:  max_moment_x_q  <= pwdata[MOM_W-1:0];
				REG_MOM_Y:  max_moment_y_q  <= pwdata[MOM_W-1:0];
				REG_MOM_Z:  max_moment_z_q  <= pwdata[MOM_W-1:0];
				REG_RES_X:  coil_res_x_q    <= pwdata[RES_W-1:0];
				REG_RES_Y:  coil_res_y_q    <= pwdata[RES_W-1:0];
				REG_RES_Z:  coil_res_z_q    <= pwdata[RES_W-1:0];
				REG_VWORST: worst_voltage_q <= pwdata[VOLT_W-1:0];
				REG_BUDGET: power_budget_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_MOM_X:  prdata = DATA_W'(max_moment_x_q);
			REG_MOM_Y:  prdata = DATA_W'(max_moment_y_q);
			REG_MOM_Z:  prdata = DATA_W'(max_moment_z_q);
			REG_RES_X:  prdata = DATA_W'(coil_res_x_q);
			REG_RES_Y:  prdata = DATA_W'(coil_res_y_q);
			REG_RES_Z:  prdata = DATA_W'(coil_res_z_q);
			REG_VWORST: prdata = DATA_W'(worst_voltage_q);
			REG_BUDGET: prdata = DATA_W'(power_budget_q);
			default:    prdata = '0;
		endcase
	end

	logic [MOM_W-1:0] mom_eff [3];
	logic [RES_W-1:0] res_eff [3];
	logic [SUMW-1:0]  budget_sh;

	// zero moment or resistance acts as one
	assign mom_eff[0] = (max_moment_x_q == '0) ? MOM_W'(1) : max_moment_x_q;
	assign mom_eff[1] = (max_moment_y_q == '0) ? MOM_W'(1) : max_moment_y_q;
	assign mom_eff[2] = (max_moment_z_q == '0) ? MOM_W'(1) : max_moment_z_q;
	assign res_eff[0] = (coil_res_x_q == '0) ? RES_W'(1) : coil_res_x_q;
	assign res_eff[1] = (coil_res_y_q == '0) ? RES_W'(1) : coil_res_y_q;
	assign res_eff[2] = (coil_res_z_q == '0) ? RES_W'(1) : coil_res_z_q;
	assign budget_sh  = SUMW'(power_budget_q) << F;

	logic en;
	logic [REQ_W-1:0] req_w [3];

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign req_w[0] = req_x;
	assign req_w[1] = req_y;
	assign req_w[2] = req_z;

	// s1: sign and magnitude, supply voltage select
	logic [REQ_W-1:0]  abs_s1 [3];
	logic [2:0]        neg_s1;
	logic [VOLT_W-1:0] volt_s1;
	logic              vld_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				abs_s1[a] <= req_w[a][REQ_W-1] ? (~req_w[a] + 1'b1) : req_w[a];
				neg_s1[a] <= req_w[a][REQ_W-1];
			end
			volt_s1 <= monitor_alive ? bus_voltage_mv : worst_voltage_q;
		end
	end

	// normalize by full-scale moment
	logic [2:0]        vld_n;
	logic [N1W-1:0]    quo_n [3];
	logic [2:0]        neg_n;
	logic [VOLT_W-1:0] volt_n;

	for (genvar a = 0; a < 3; a++) begin : g_norm
		localparam int SWN = (a == 0) ? VOLT_W + 1 : 1;
		logic [SWN-1:0] side_i, side_o;

		if (a == 0) begin : g_v
			assign side_i = {neg_s1[a], volt_s1};
			assign volt_n = side_o[VOLT_W-1:0];
		end else begin : g_nv
			assign side_i = neg_s1[a];
		end
		assign neg_n[a] = side_o[SWN-1];

		mda_div #(.DW(MOM_W), .QW(N1W), .SW(SWN)) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_s1),
			.rem_i  ('0),
			.low_i  ({abs_s1[a], (F + 1)'(0)}),
			.den_i  (mom_eff[a]),
			.side_i (side_i),
			.vld_o  (vld_n[a]),
			.quo_o  (quo_n[a]),
			.side_o (side_o)
		);
	end

	// s2: round the normalized magnitude
	logic [MW-1:0]     mag_s2 [3];
	logic [2:0]        neg_s2;
	logic [VOLT_W-1:0] volt_s2;
	logic              vld_s2;
	logic [N1W:0]      q1p [3];

	always_comb begin
		for (int a = 0; a < 3; a++) q1p[a] = {1'b0, quo_n[a]} + (N1W + 1)'(1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) mag_s2[a] <= q1p[a][MW:1];
			neg_s2  <= neg_n;
			volt_s2 <= volt_n;
		end
	end

	// s3: largest magnitude
	logic [MW-1:0]     mag_s3 [3];
	logic [MW-1:0]     mx_s3;
	logic              clamp_s3;
	logic [2:0]        neg_s3;
	logic [VOLT_W-1:0] volt_s3;
	logic              vld_s3;
	logic [MW-1:0]     mx_c;

	always_comb begin
		mx_c = mag_s2[0];
		if (mag_s2[1] > mx_c) mx_c = mag_s2[1];
		if (mag_s2[2] > mx_c) mx_c = mag_s2[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3   <= mag_s2;
			mx_s3    <= mx_c;
			clamp_s3 <= mx_c > ONE_M;
			neg_s3   <= neg_s2;
			volt_s3  <= volt_s2;
		end
	end

	// uniform clamp: mag * 2^(F+1) / mx
	logic [2:0]        vld_c;
	logic [CQW-1:0]    quo_c [3];
	logic [2:0]        clamp_c;
	logic [2:0]        neg_c;
	logic [AW-1:0]     orig_c [3];
	logic [VOLT_W-1:0] volt_c;

	for (genvar a = 0; a < 3; a++) begin : g_clamp
		localparam int SWC = (a == 0) ? AW + 2 + VOLT_W : AW + 2;
		logic [SWC-1:0] side_i, side_o;

		if (a == 0) begin : g_v
			assign side_i = {clamp_s3, neg_s3[a], AW'(mag_s3[a]), volt_s3};
			assign volt_c = side_o[VOLT_W-1:0];
		end else begin : g_nv
			assign side_i = {clamp_s3, neg_s3[a], AW'(mag_s3[a])};
		end
		assign clamp_c[a] = side_o[SWC-1];
		assign neg_c[a]   = side_o[SWC-2];
		assign orig_c[a]  = side_o[SWC-3 -: AW];

		mda_div #(.DW(MW), .QW(CQW), .SW(SWC)) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_s3),
			.rem_i  (mag_s3[a] >> 1),
			.low_i  ({mag_s3[a][0], (F + 1)'(0)}),
			.den_i  (mx_s3),
			.side_i (side_i),
			.vld_o  (vld_c[a]),
			.quo_o  (quo_c[a]),
			.side_o (side_o)
		);
	end

	// s4: duty magnitude, at most one
	logic [AW-1:0]     mag_s4 [3];
	logic [2:0]        neg_s4;
	logic [VOLT_W-1:0] volt_s4;
	logic              vld_s4;
	logic [CQW:0]      c2p [3];

	always_comb begin
		for (int a = 0; a < 3; a++) c2p[a] = {1'b0, quo_c[a]} + (CQW + 1)'(1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) mag_s4[a] <= clamp_c[a] ? c2p[a][AW:1] : orig_c[a];
			neg_s4  <= neg_c;
			volt_s4 <= volt_c;
		end
	end

	// s5: duty squared and voltage squared
	logic [AW-1:0]       u_s5 [3];
	logic [AW-1:0]       mag_s5 [3];
	logic [2*VOLT_W-1:0] v2_s5;
	logic [2:0]          neg_s5;
	logic                vld_s5;
	logic [2*AW-1:0]     sq [3];

	always_comb begin
		for (int a = 0; a < 3; a++) sq[a] = (2 * AW)'(mag_s4[a]) * (2 * AW)'(mag_s4[a]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) u_s5[a] <= sq[a][F+AW-1:F];
			mag_s5 <= mag_s4;
			v2_s5  <= (2 * VOLT_W)'(volt_s4) * (2 * VOLT_W)'(volt_s4);
			neg_s5 <= neg_s4;
		end
	end

	// s6: per-axis duty^2 * V^2
	logic [PW-1:0] p_s6 [3];
	logic [AW-1:0] mag_s6 [3];
	logic [2:0]    neg_s6;
	logic          vld_s6;
	logic [PPW-1:0] pp [3];

	always_comb begin
		for (int a = 0; a < 3; a++) pp[a] = PPW'(u_s5[a]) * PPW'(v2_s5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) p_s6[a] <= pp[a][PW-1:0];
			mag_s6 <= mag_s5;
			neg_s6 <= neg_s5;
		end
	end

	// divide by coil resistance
	logic [2:0]    vld_p;
	logic [PW-1:0] quo_p [3];
	logic [2:0]    neg_p;
	logic [AW-1:0] mag_p [3];

	for (genvar a = 0; a < 3; a++) begin : g_pow
		logic [AW:0] side_o;

		assign neg_p[a] = side_o[AW];
		assign mag_p[a] = side_o[AW-1:0];

		mda_div #(.DW(RES_W), .QW(PW), .SW(AW + 1)) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_s6),
			.rem_i  ('0),
			.low_i  (p_s6[a]),
			.den_i  (res_eff[a]),
			.side_i ({neg_s6[a], mag_s6[a]}),
			.vld_o  (vld_p[a]),
			.quo_o  (quo_p[a]),
			.side_o (side_o)
		);
	end

	// s7: total power
	logic [SUMW-1:0] power_s7;
	logic [AW-1:0]   mag_s7 [3];
	logic [2:0]      neg_s7;
	logic            vld_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			power_s7 <= SUMW'(quo_p[0]) + SUMW'(quo_p[1]) + SUMW'(quo_p[2]);
			mag_s7   <= mag_p;
			neg_s7   <= neg_p;
		end
	end

	// s8: budget check
	logic [SUMW-1:0] power_s8;
	logic            over_s8;
	logic [AW-1:0]   mag_s8 [3];
	logic [2:0]      neg_s8;
	logic            vld_s8;
	logic [SW4-1:0]  side4_i, side4_o;

	always_ff @(posedge clk) begin
		if (en) begin
			power_s8 <= power_s7;
			over_s8  <= power_s7 > budget_sh;
			mag_s8   <= mag_s7;
			neg_s8   <= neg_s7;
		end
	end

	always_comb begin
		side4_i = '0;
		for (int a = 0; a < 3; a++) begin
			side4_i[a*AW +: AW] = mag_s8[a];
			side4_i[3*AW + a]   = neg_s8[a];
		end
		side4_i[3*AW+3] = over_s8;
	end

	// budget ratio in Q.2F
	logic           vld_r;
	logic [RQW-1:0] quo_r;

	mda_div #(.DW(SUMW), .QW(RQW), .SW(SW4)) u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s8),
		.rem_i  (budget_sh),
		.low_i  ('0),
		.den_i  (power_s8),
		.side_i (side4_i),
		.vld_o  (vld_r),
		.quo_o  (quo_r),
		.side_o (side4_o)
	);

	// square root, one result bit per stage
	logic [F+1:0]   sq_rem_s  [F];
	logic [F-1:0]   sq_root_s [F];
	logic [RQW-1:0] sq_rad_s  [F];
	logic [SW4-1:0] sq_side_s [F];
	logic [F-1:0]   sq_vld_s;

	for (genvar j = 0; j < F; j++) begin : g_sqrt
		logic [F+1:0]   rem_c;
		logic [F-1:0]   root_c;
		logic [RQW-1:0] rad_c;
		logic [SW4-1:0] side_c;
		logic           vld_cc;
		logic [F+3:0]   pre;
		logic [F+3:0]   trial;
		logic           ge;

		if (j == 0) begin : g_first
			assign rem_c  = '0;
			assign root_c = '0;
			assign rad_c  = quo_r;
			assign side_c = side4_o;
			assign vld_cc = vld_r;
		end else begin : g_next
			assign rem_c  = sq_rem_s[j-1];
			assign root_c = sq_root_s[j-1];
			assign rad_c  = sq_rad_s[j-1];
			assign side_c = sq_side_s[j-1];
			assign vld_cc = sq_vld_s[j-1];
		end

		assign pre   = {rem_c, rad_c[RQW-1 -: 2]};
		assign trial = (F + 4)'({root_c, 2'b01});
		assign ge    = pre >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[j]  <= ge ? (F + 2)'(pre - trial) : pre[F+1:0];
				sq_root_s[j] <= {root_c[F-2:0], ge};
				sq_rad_s[j]  <= rad_c << 2;
				sq_side_s[j] <= side_c;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[j] <= 1'b0;
			end else if (en) begin
				sq_vld_s[j] <= vld_cc;
			end
		end
	end

	// s9: scale by the root when over budget
	logic [AW-1:0]   mag_s9 [3];
	logic [2:0]      neg_s9;
	logic            vld_s9;
	logic [AW+F-1:0] scl [3];
	logic [SW4-1:0]  sq_side;
	logic [F-1:0]    root;

	assign sq_side = sq_side_s[F-1];
	assign root    = sq_root_s[F-1];

	always_comb begin
		for (int a = 0; a < 3; a++)
			scl[a] = (AW + F)'(sq_side[a*AW +: AW]) * (AW + F)'(root);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				mag_s9[a] <= sq_side[3*AW+3] ? scl[a][F+AW-1:F] : sq_side[a*AW +: AW];
				neg_s9[a] <= sq_side[3*AW + a];
			end
		end
	end

	// s10: moment product and saturated duty
	logic [PRW-1:0]    prod_s10 [3];
	logic [DUTY_W-1:0] duty_s10 [3];
	logic [2:0]        neg_s10;
	logic              vld_s10;
	logic [CW-1:0]     cmag [3];
	logic [DUTY_W-1:0] dval [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			cmag[a] = CW'(mag_s9[a]);
			if (neg_s9[a]) begin
				dval[a] = (cmag[a] > CW'(DUTY_NEG_LIM)) ? DUTY_MIN : (~cmag[a][DUTY_W-1:0] + 1'b1);
			end else begin
				dval[a] = (cmag[a] > CW'(DUTY_POS_LIM)) ? DUTY_MAX : cmag[a][DUTY_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) prod_s10[a] <= PRW'(mag_s9[a]) * PRW'(mom_eff[a]);
			duty_s10 <= dval;
			neg_s10  <= neg_s9;
		end
	end

	// s11: round the moment, apply sign
	logic [DUTY_W-1:0]  duty_s11  [3];
	logic [ALLOC_W-1:0] alloc_s11 [3];
	logic               vld_s11;
	logic [TW:0]        rnd [3];
	logic [ALLOC_W-1:0] amag [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			rnd[a]  = {1'b0, prod_s10[a][PRW-1:F-1]} + (TW + 1)'(1);
			amag[a] = rnd[a][ALLOC_W:1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++)
				alloc_s11[a] <= neg_s10[a] ? (~amag[a] + 1'b1) : amag[a];
			duty_s11 <= duty_s10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_n[0];
			vld_s3  <= vld_s2;
			vld_s4  <= vld_c[0];
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_p[0];
			vld_s8  <= vld_s7;
			vld_s9  <= sq_vld_s[F-1];
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	assign out_valid = vld_s11;
	assign duty_x    = duty_s11[0];
	assign duty_y    = duty_s11[1];
	assign duty_z    = duty_s11[2];
	assign alloc_x   = alloc_s11[0];
	assign alloc_y   = alloc_s11[1];
	assign alloc_z   = alloc_s11[2];

	`ASSERT_ALWAYS(a_lanes_aligned, clk, arst_n,
		(vld_n[1] == vld_n[0]) && (vld_n[2] == vld_n[0]) && (vld_c[1] == vld_c[0]) && (vld_c[2] == vld_c[0]) && (vld_p[1] == vld_p[0]) && (vld_p[2] == vld_p[0]),
		"axis lanes out of step")
	`ASSERT_IMPLY(a_clamp_bound, clk, arst_n, vld_s4,
		(mag_s4[0] <= ONE_A) && (mag_s4[1] <= ONE_A) && (mag_s4[2] <= ONE_A),
		"duty magnitude above one after clamp")
	`ASSERT_IMPLY(a_sign_match, clk, arst_n, out_valid && duty_x[DUTY_W-1],
		alloc_x[ALLOC_W-1] || (alloc_x == '0),
		"alloc sign differs from duty sign")

endmodule
